### rtl/imu_cal_pkg.sv
// Shared types and constants for the IMU bias calibration and activity classifier.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package imu_cal_pkg;

    // Field widths and axis layout (gyro x, y, z, then accel x, y, z).
    localparam int AXIS_W      = 16;
    localparam int NUM_AXES    = 6;
    localparam int AXIS_IDX_W  = 3;
    localparam int COUNT_W     = 16;
    localparam int GRAVITY_W   = 15;
    localparam int THRESH_W    = 32;
    localparam int SQUARE_W    = 31;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [AXIS_IDX_W-1:0] AXIS_ACCEL_Z = 3'd5;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_CALIB_SAMPLES  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRAVITY_COUNTS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_STILL_SQ = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_WALK_SQ  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GYRO_STILL_SQ  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_GYRO_WALK_SQ   = 3'd5;

    localparam logic [COUNT_W-1:0]   RST_CALIB_SAMPLES  = 16'd100;
    localparam logic [GRAVITY_W-1:0] RST_GRAVITY_COUNTS = 15'd16384;
    localparam logic [THRESH_W-1:0]  RST_ACCEL_STILL_SQ = 32'd698228;
    localparam logic [THRESH_W-1:0]  RST_ACCEL_WALK_SQ  = 32'd11169000;
    localparam logic [THRESH_W-1:0]  RST_GYRO_STILL_SQ  = 32'd326531;
    localparam logic [THRESH_W-1:0]  RST_GYRO_WALK_SQ   = 32'd5224490;

    // Input operation codes and result kinds.
    localparam logic OP_MEASURE   = 1'b0;
    localparam logic OP_CALIBRATE = 1'b1;

    localparam logic RESULT_MEASURE   = 1'b0;
    localparam logic RESULT_CAL_DONE  = 1'b1;

    typedef enum logic [1:0] {
        ACT_STATIONARY = 2'd0,
        ACT_WALKING    = 2'd1,
        ACT_RUNNING    = 2'd2
    } activity_t;

    // What the front end decided an accepted sample is.
    typedef enum logic [1:0] {
        KIND_MEASURE  = 2'd0,
        KIND_CAL_ADD  = 2'd1,
        KIND_CAL_LAST = 2'd2
    } kind_t;

    // One queue entry between front and back end.
    typedef struct packed {
        kind_t                              kind;
        logic [COUNT_W-1:0]                 count;
        logic [NUM_AXES-1:0][AXIS_W-1:0]    axis;
    } item_t;

    // Configuration register file.
    typedef struct packed {
        logic [COUNT_W-1:0]   calib_samples;
        logic [GRAVITY_W-1:0] gravity_counts;
        logic [THRESH_W-1:0]  accel_still_sq;
        logic [THRESH_W-1:0]  accel_walk_sq;
        logic [THRESH_W-1:0]  gyro_still_sq;
        logic [THRESH_W-1:0]  gyro_walk_sq;
    } cfg_t;

endpackage

### rtl/imu_cal_if.sv
// Valid/ready channel interfaces for raw samples and results.
// Depends on imu_cal_pkg for the field widths.
`timescale 1ns / 1ps

interface imu_cal_sample_if import imu_cal_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic signed [AXIS_W-1:0] gyro_x;
    logic signed [AXIS_W-1:0] gyro_y;
    logic signed [AXIS_W-1:0] gyro_z;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;

    modport source (output valid, operation, gyro_x, gyro_y, gyro_z,
                    accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, operation, gyro_x, gyro_y, gyro_z,
                    accel_x, accel_y, accel_z, output ready);
endinterface

interface imu_cal_result_if import imu_cal_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     result_kind;
    logic signed [AXIS_W-1:0] gyro_x_corr;
    logic signed [AXIS_W-1:0] gyro_y_corr;
    logic signed [AXIS_W-1:0] gyro_z_corr;
    logic signed [AXIS_W-1:0] accel_x_corr;
    logic signed [AXIS_W-1:0] accel_y_corr;
    logic signed [AXIS_W-1:0] accel_z_corr;
    logic [1:0]               activity;
    logic                     calibrated;

    modport source (output valid, result_kind, gyro_x_corr, gyro_y_corr, gyro_z_corr,
                    accel_x_corr, accel_y_corr, accel_z_corr, activity, calibrated,
                    input ready);
    modport sink   (input valid, result_kind, gyro_x_corr, gyro_y_corr, gyro_z_corr,
                    accel_x_corr, accel_y_corr, accel_z_corr, activity, calibrated,
                    output ready);
endinterface

### rtl/imu_bias_calibration_activity_classifier.sv
// A measurement is corrected, squared, classified and registered, one queued item at a time.
// A non-final calibration sample only adds to the running sums and produces no result.
// A final calibration sample has the shared one-bit-per-cycle divider form the six offsets
// in turn.
// Reset clears sums, offsets, sample count and calibrated flag and loads default thresholds;
// no clearing pass is needed, so samples are taken the cycle after reset is released.
`timescale 1ns / 1ps

module imu_bias_calibration_activity_classifier import imu_cal_pkg::*;
#(
    parameter int SUM_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    imu_cal_sample_if.sink         samples,
    imu_cal_result_if.source       results
);

    cfg_t   cfg_reg;
    logic   push;
    item_t  push_item;
    logic   queue_full;
    logic   pop;
    item_t  pop_item;
    logic   queue_empty;

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.calib_samples  <= RST_CALIB_SAMPLES;
            cfg_reg.gravity_counts <= RST_GRAVITY_COUNTS;
            cfg_reg.accel_still_sq <= RST_ACCEL_STILL_SQ;
            cfg_reg.accel_walk_sq  <= RST_ACCEL_WALK_SQ;
            cfg_reg.gyro_still_sq  <= RST_GYRO_STILL_SQ;
            cfg_reg.gyro_walk_sq   <= RST_GYRO_WALK_SQ;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CALIB_SAMPLES:  cfg_reg.calib_samples  <= cfg_data[COUNT_W-1:0];
                REG_GRAVITY_COUNTS: cfg_reg.gravity_counts <= cfg_data[GRAVITY_W-1:0];
                REG_ACCEL_STILL_SQ: cfg_reg.accel_still_sq <= cfg_data[THRESH_W-1:0];
                REG_ACCEL_WALK_SQ:  cfg_reg.accel_walk_sq  <= cfg_data[THRESH_W-1:0];
                REG_GYRO_STILL_SQ:  cfg_reg.gyro_still_sq  <= cfg_data[THRESH_W-1:0];
                REG_GYRO_WALK_SQ:   cfg_reg.gyro_walk_sq   <= cfg_data[THRESH_W-1:0];
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    imu_cal_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .calib_samples (cfg_reg.calib_samples),
        .samples       (samples),
        .queue_full    (queue_full),
        .push          (push),
        .push_item     (push_item)
    );

    imu_cal_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (queue_empty)
    );

    imu_cal_back #(.SUM_WIDTH(SUM_WIDTH)) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .pop_item    (pop_item),
        .queue_empty (queue_empty),
        .pop         (pop),
        .results     (results)
    );

endmodule

### rtl/imu_cal_front.sv
// Front end: accepts sample transactions, counts calibration samples and tags the last one.
// Depends on imu_cal_pkg and imu_cal_sample_if.
`timescale 1ns / 1ps

module imu_cal_front import imu_cal_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [COUNT_W-1:0]    calib_samples,
    imu_cal_sample_if.sink        samples,
    input  logic                  queue_full,
    output logic                  push,
    output item_t                 push_item
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] target;
    logic               run_done;

    assign samples.ready = !queue_full;
    assign push          = samples.valid && samples.ready;

    // A zero sample count behaves as one.
    assign target    = (calib_samples == '0) ? COUNT_W'(1) : calib_samples;
    assign count_inc = count_reg + COUNT_W'(1);
    assign run_done  = (count_inc != '0) && (count_inc >= target);

    // Classify the transaction and update the calibration sample count.
    always_comb
    begin
        count_next          = count_reg;
        push_item.kind      = KIND_MEASURE;
        push_item.count     = count_inc;
        push_item.axis[0]   = samples.gyro_x;
        push_item.axis[1]   = samples.gyro_y;
        push_item.axis[2]   = samples.gyro_z;
        push_item.axis[3]   = samples.accel_x;
        push_item.axis[4]   = samples.accel_y;
        push_item.axis[5]   = samples.accel_z;
        case (samples.operation)
            OP_CALIBRATE:
            begin
                push_item.kind = run_done ? KIND_CAL_LAST : KIND_CAL_ADD;
                count_next     = run_done ? '0 : count_inc;
            end
            default:
            begin
                push_item.kind = KIND_MEASURE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (push)
        begin
            count_reg <= count_next;
        end
    end

endmodule

### rtl/imu_cal_fifo.sv
// Short queue of classified samples between the front and back ends.
// Depends on imu_cal_pkg for the entry type and depth.
`timescale 1ns / 1ps

module imu_cal_fifo import imu_cal_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t pop_item,
    output logic  empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;

    assign full     = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
            fill_reg <= fill_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/imu_cal_div.sv
// Radix-2 restoring divider: a SUM_WIDTH-bit magnitude by a 16-bit count, one bit per cycle.
// Depends on imu_cal_pkg for the axis and count widths.
`timescale 1ns / 1ps

module imu_cal_div import imu_cal_pkg::*;
#(
    parameter int SUM_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SUM_WIDTH-1:0] dividend,
    input  logic [COUNT_W-1:0]   divisor,
    output logic                 busy,
    output logic                 done,
    output logic [AXIS_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(SUM_WIDTH + 1);

    logic [COUNT_W-1:0]   rem_reg;
    logic [COUNT_W-1:0]   rem_next;
    logic [SUM_WIDTH-1:0] dvd_reg;
    logic [SUM_WIDTH-1:0] dvd_next;
    logic [COUNT_W-1:0]   dsr_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [COUNT_W:0]     shifted;
    logic [COUNT_W:0]     diff;
    logic                 fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign shifted = {rem_reg, dvd_reg[SUM_WIDTH-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign fits    = (shifted >= {1'b0, dsr_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            cnt_next  = CNT_W'(SUM_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
            dvd_next = {dvd_reg[SUM_WIDTH-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dvd_reg[AXIS_W-1:0];

endmodule

### rtl/imu_cal_back.sv
// Back end: accumulates calibration sums, computes offsets, corrects and classifies samples.
// Depends on imu_cal_pkg, imu_cal_result_if and imu_cal_div.
`timescale 1ns / 1ps

module imu_cal_back import imu_cal_pkg::*;
#(
    parameter int SUM_WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  item_t            pop_item,
    input  logic             queue_empty,
    output logic             pop,
    imu_cal_result_if.source results
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_COMPARE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [SUM_WIDTH-1:0]   sums_reg [NUM_AXES];
    logic [SUM_WIDTH-1:0]   sums_next [NUM_AXES];
    logic [AXIS_W-1:0]      offsets_reg [NUM_AXES];
    logic [AXIS_W-1:0]      offsets_next [NUM_AXES];
    logic                   calibrated_reg;
    logic                   calibrated_next;
    logic [AXIS_W-1:0]      corr_reg [NUM_AXES];
    logic [AXIS_W-1:0]      corr_next [NUM_AXES];
    logic [SQUARE_W-1:0]    square_reg [NUM_AXES];
    logic [SQUARE_W-1:0]    square_next [NUM_AXES];
    logic signed [31:0]     product [NUM_AXES];
    activity_t              act_reg;
    activity_t              act_next;
    logic                   kind_reg;
    logic                   kind_next;
    logic [AXIS_IDX_W-1:0]  axis_reg;
    logic [AXIS_IDX_W-1:0]  axis_next;
    logic                   sign_reg;
    logic                   sign_next;
    logic [COUNT_W-1:0]     divisor_reg;
    logic [COUNT_W-1:0]     divisor_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_kind_reg;
    logic [AXIS_W-1:0]      out_corr_reg [NUM_AXES];
    activity_t              out_act_reg;
    logic                   out_cal_reg;
    logic                   out_load;

    logic [THRESH_W-1:0]    gyro_sq_sum;
    logic [THRESH_W-1:0]    accel_sq_sum;
    logic [SUM_WIDTH-1:0]   sel_sum;
    logic                   div_start;
    logic [SUM_WIDTH-1:0]   div_dividend;
    logic                   div_busy;
    logic                   div_done;
    logic [AXIS_W-1:0]      div_quot;
    logic [AXIS_W-1:0]      quot_signed;
    logic [AXIS_W-1:0]      offset_new;

    imu_cal_div #(.SUM_WIDTH(SUM_WIDTH)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (divisor_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Squares of the corrected axes; each fits in 31 unsigned bits.
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            product[i] = $signed(corr_reg[i]) * $signed(corr_reg[i]);
        end
    end

    // Squared magnitudes; three 31-bit squares stay below 2^32.
    assign gyro_sq_sum  = THRESH_W'(square_reg[0]) + THRESH_W'(square_reg[1])
                        + THRESH_W'(square_reg[2]);
    assign accel_sq_sum = THRESH_W'(square_reg[3]) + THRESH_W'(square_reg[4])
                        + THRESH_W'(square_reg[5]);

    // Signed sum to magnitude for the divider; quotient back to a signed offset.
    assign sel_sum      = sums_reg[axis_reg];
    assign div_dividend = sel_sum[SUM_WIDTH-1] ? (~sel_sum + SUM_WIDTH'(1)) : sel_sum;
    assign quot_signed  = sign_reg ? (~div_quot + AXIS_W'(1)) : div_quot;
    assign offset_new   = (axis_reg == AXIS_ACCEL_Z)
                        ? (quot_signed - {1'b0, cfg.gravity_counts})
                        : quot_signed;

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || results.ready);

    // Sequencer for one queued item at a time.
    always_comb
    begin
        state_next      = state_reg;
        sums_next       = sums_reg;
        offsets_next    = offsets_reg;
        calibrated_next = calibrated_reg;
        corr_next       = corr_reg;
        square_next     = square_reg;
        act_next        = act_reg;
        kind_next       = kind_reg;
        axis_next       = axis_reg;
        sign_next       = sign_reg;
        divisor_next    = divisor_reg;
        pop             = 1'b0;
        div_start       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop = 1'b1;
                    case (pop_item.kind)
                        KIND_MEASURE:
                        begin
                            for (int i = 0; i < NUM_AXES; i++)
                            begin
                                corr_next[i] = calibrated_reg
                                             ? (pop_item.axis[i] - offsets_reg[i])
                                             : pop_item.axis[i];
                            end
                            kind_next  = RESULT_MEASURE;
                            state_next = ST_SQUARE;
                        end
                        KIND_CAL_ADD, KIND_CAL_LAST:
                        begin
                            for (int i = 0; i < NUM_AXES; i++)
                            begin
                                sums_next[i] = sums_reg[i]
                                    + {{(SUM_WIDTH-AXIS_W){pop_item.axis[i][AXIS_W-1]}},
                                       pop_item.axis[i]};
                            end
                            if (pop_item.kind == KIND_CAL_LAST)
                            begin
                                divisor_next = pop_item.count;
                                axis_next    = '0;
                                state_next   = ST_DIV_START;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SQUARE:
            begin
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    square_next[i] = product[i][SQUARE_W-1:0];
                end
                state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                if ((accel_sq_sum < cfg.accel_still_sq) && (gyro_sq_sum < cfg.gyro_still_sq))
                begin
                    act_next = ACT_STATIONARY;
                end
                else if ((accel_sq_sum < cfg.accel_walk_sq)
                         && (gyro_sq_sum < cfg.gyro_walk_sq))
                begin
                    act_next = ACT_WALKING;
                end
                else
                begin
                    act_next = ACT_RUNNING;
                end
                state_next = ST_OUT;
            end
            ST_DIV_START:
            begin
                div_start  = 1'b1;
                sign_next  = sel_sum[SUM_WIDTH-1];
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    offsets_next[axis_reg] = offset_new;
                    if (axis_reg == AXIS_ACCEL_Z)
                    begin
                        calibrated_next = 1'b1;
                        for (int i = 0; i < NUM_AXES; i++)
                        begin
                            sums_next[i] = '0;
                            corr_next[i] = '0;
                        end
                        act_next   = ACT_STATIONARY;
                        kind_next  = RESULT_CAL_DONE;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        axis_next  = axis_reg + AXIS_IDX_W'(1);
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid: held until the transaction completes.
    always_comb
    begin
        out_valid_next = out_valid_reg && !results.ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Sequencer state, working registers and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            calibrated_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            axis_reg       <= '0;
            act_reg        <= ACT_STATIONARY;
            kind_reg       <= RESULT_MEASURE;
            sign_reg       <= 1'b0;
            divisor_reg    <= '0;
            out_kind_reg   <= RESULT_MEASURE;
            out_act_reg    <= ACT_STATIONARY;
            out_cal_reg    <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                sums_reg[i]     <= '0;
                offsets_reg[i]  <= '0;
                corr_reg[i]     <= '0;
                square_reg[i]   <= '0;
                out_corr_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            calibrated_reg <= calibrated_next;
            out_valid_reg  <= out_valid_next;
            axis_reg       <= axis_next;
            sums_reg       <= sums_next;
            offsets_reg    <= offsets_next;
            corr_reg       <= corr_next;
            square_reg     <= square_next;
            act_reg        <= act_next;
            kind_reg       <= kind_next;
            sign_reg       <= sign_next;
            divisor_reg    <= divisor_next;
            if (out_load)
            begin
                out_kind_reg <= kind_reg;
                out_corr_reg <= corr_reg;
                out_act_reg  <= act_reg;
                out_cal_reg  <= calibrated_reg;
            end
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.result_kind   = out_kind_reg;
    assign results.gyro_x_corr   = out_corr_reg[0];
    assign results.gyro_y_corr   = out_corr_reg[1];
    assign results.gyro_z_corr   = out_corr_reg[2];
    assign results.accel_x_corr  = out_corr_reg[3];
    assign results.accel_y_corr  = out_corr_reg[4];
    assign results.accel_z_corr  = out_corr_reg[5];
    assign results.activity      = out_act_reg;
    assign results.calibrated    = out_cal_reg;

`ifndef ASSERT_OFF
    // The divider is never restarted while a division is in flight.
    assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_busy)
        else $error("divider started while busy");

    // Finishing the last axis sets the flag and queues a completion result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_WAIT && div_done && axis_reg == AXIS_ACCEL_Z)
        |=> (calibrated_reg && state_reg == ST_OUT && kind_reg == RESULT_CAL_DONE))
        else $error("calibration end did not produce a completion result");

    // The running sums are cleared when a calibration run ends.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_WAIT && div_done && axis_reg == AXIS_ACCEL_Z)
        |=> (sums_reg[0] == '0 && sums_reg[3] == '0 && sums_reg[5] == '0))
        else $error("sums not cleared after calibration");
`endif

endmodule

### tb/sv/imu_cal_result_checker.sv
// Result checker for the IMU bias calibration and activity classifier.
// Watches the sample, result and configuration ports; depends on imu_cal_pkg and imu_cal_if.
`timescale 1ns / 1ps

module imu_cal_result_checker import imu_cal_pkg::*;
#(
    parameter int SUM_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    imu_cal_sample_if              samples,
    imu_cal_result_if              results,
    output int                     mismatches,
    output int                     outstanding
);

    typedef struct packed {
        logic                            kind;
        logic [NUM_AXES-1:0][AXIS_W-1:0] corr;
        activity_t                       activity;
        logic                            calibrated;
    } imu_result_t;

    // Shadow copy of the configuration and the calibration state.
    cfg_t                 model_cfg;
    logic [SUM_WIDTH-1:0] axis_sum    [NUM_AXES];
    logic [AXIS_W-1:0]    axis_offset [NUM_AXES];
    logic [COUNT_W-1:0]   cal_count;
    logic                 offsets_valid;
    int                   fail_count;

    imu_result_t expected_results [$];

    // Signed sum over the count, truncated toward zero, kept to 16 bits.
    function automatic logic [AXIS_W-1:0] mean_toward_zero(input logic [SUM_WIDTH-1:0] sum,
                                                          input logic [COUNT_W-1:0] count);
        logic signed [63:0] total;
        logic [63:0]        mag;
        logic [63:0]        quot;
        total = $signed(sum);
        mag = (total < 0) ? -total : total;
        quot = mag / {48'd0, count};
        if (total < 0)
            quot = -quot;
        return quot[AXIS_W-1:0];
    endfunction

    // Advances the shadow state by one sample; returns 1 when the sample yields a result.
    function automatic bit predict_sample(input logic op,
                                          input logic [NUM_AXES-1:0][AXIS_W-1:0] raw,
                                          output imu_result_t res);
        logic [COUNT_W-1:0] target;
        logic signed [63:0] v;
        logic [63:0]        gyro_sq;
        logic [63:0]        accel_sq;
        res = '0;
        if (op == OP_CALIBRATE) begin
            target = (model_cfg.calib_samples == 0) ? COUNT_W'(1) : model_cfg.calib_samples;
            for (int i = 0; i < NUM_AXES; i++)
                axis_sum[i] = axis_sum[i]
                            + {{(SUM_WIDTH-AXIS_W){raw[i][AXIS_W-1]}}, raw[i]};
            cal_count = cal_count + 1'b1;
            if (cal_count == 0 || cal_count < target)
                return 1'b0;
            for (int i = 0; i < NUM_AXES; i++)
                axis_offset[i] = mean_toward_zero(axis_sum[i], cal_count);
            axis_offset[AXIS_ACCEL_Z] = axis_offset[AXIS_ACCEL_Z]
                                      - {1'b0, model_cfg.gravity_counts};
            offsets_valid = 1'b1;
            for (int i = 0; i < NUM_AXES; i++)
                axis_sum[i] = '0;
            cal_count = '0;
            res.kind       = RESULT_CAL_DONE;
            res.activity   = ACT_STATIONARY;
            res.calibrated = 1'b1;
            return 1'b1;
        end
        gyro_sq  = '0;
        accel_sq = '0;
        for (int i = 0; i < NUM_AXES; i++)
            res.corr[i] = offsets_valid ? raw[i] - axis_offset[i] : raw[i];
        for (int i = 0; i < 3; i++) begin
            v = $signed(res.corr[i]);
            gyro_sq += v * v;
            v = $signed(res.corr[3 + i]);
            accel_sq += v * v;
        end
        if (accel_sq < {32'd0, model_cfg.accel_still_sq}
            && gyro_sq < {32'd0, model_cfg.gyro_still_sq})
            res.activity = ACT_STATIONARY;
        else if (accel_sq < {32'd0, model_cfg.accel_walk_sq}
                 && gyro_sq < {32'd0, model_cfg.gyro_walk_sq})
            res.activity = ACT_WALKING;
        else
            res.activity = ACT_RUNNING;
        res.kind       = RESULT_MEASURE;
        res.calibrated = offsets_valid;
        return 1'b1;
    endfunction

    task automatic note_field(input string field, input logic [AXIS_W-1:0] want,
                              input logic [AXIS_W-1:0] got);
        if (want !== got) begin
            if (fail_count < 10)
                $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        imu_result_t                     want;
        imu_result_t                     got;
        logic [NUM_AXES-1:0][AXIS_W-1:0] raw;
        if (!rst_n) begin
            model_cfg.calib_samples  = RST_CALIB_SAMPLES;
            model_cfg.gravity_counts = RST_GRAVITY_COUNTS;
            model_cfg.accel_still_sq = RST_ACCEL_STILL_SQ;
            model_cfg.accel_walk_sq  = RST_ACCEL_WALK_SQ;
            model_cfg.gyro_still_sq  = RST_GYRO_STILL_SQ;
            model_cfg.gyro_walk_sq   = RST_GYRO_WALK_SQ;
            for (int i = 0; i < NUM_AXES; i++) begin
                axis_sum[i]    = '0;
                axis_offset[i] = '0;
            end
            cal_count     = '0;
            offsets_valid = 1'b0;
            fail_count    = 0;
            expected_results.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end else begin
            // Compare a result transaction with the oldest expectation.
            if (results.valid && results.ready) begin
                got.kind       = results.result_kind;
                got.corr       = {results.accel_z_corr, results.accel_y_corr,
                                  results.accel_x_corr, results.gyro_z_corr,
                                  results.gyro_y_corr, results.gyro_x_corr};
                got.activity   = activity_t'(results.activity);
                got.calibrated = results.calibrated;
                if (expected_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: result transaction with nothing expected", $time);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    note_field("result_kind", AXIS_W'(want.kind), AXIS_W'(got.kind));
                    for (int i = 0; i < NUM_AXES; i++)
                        note_field($sformatf("axis %0d corr", i), want.corr[i], got.corr[i]);
                    note_field("activity", AXIS_W'(want.activity), AXIS_W'(got.activity));
                    note_field("calibrated", AXIS_W'(want.calibrated),
                               AXIS_W'(got.calibrated));
                end
            end

            // Predict what an accepted sample transaction will produce.
            if (samples.valid && samples.ready) begin
                raw = {samples.accel_z, samples.accel_y, samples.accel_x,
                       samples.gyro_z, samples.gyro_y, samples.gyro_x};
                if (predict_sample(samples.operation, raw, want))
                    expected_results.push_back(want);
            end

            // The checker assumes register writes only happen while the block is idle; it does not enforce it.
            if (cfg_we) begin
                case (cfg_index)
                    REG_CALIB_SAMPLES:  model_cfg.calib_samples  = cfg_data[COUNT_W-1:0];
                    REG_GRAVITY_COUNTS: model_cfg.gravity_counts = cfg_data[GRAVITY_W-1:0];
                    REG_ACCEL_STILL_SQ: model_cfg.accel_still_sq = cfg_data[THRESH_W-1:0];
                    REG_ACCEL_WALK_SQ:  model_cfg.accel_walk_sq  = cfg_data[THRESH_W-1:0];
                    REG_GYRO_STILL_SQ:  model_cfg.gyro_still_sq  = cfg_data[THRESH_W-1:0];
                    REG_GYRO_WALK_SQ:   model_cfg.gyro_walk_sq   = cfg_data[THRESH_W-1:0];
                    default: ;
                endcase
            end

            mismatches  <= fail_count;
            outstanding <= expected_results.size();
        end
    end

endmodule

### tb/sv/tb_imu_bias_calibration_activity_classifier.sv
// Top of the testbench: clock, reset, sample and configuration stimulus, and the verdict.
// Depends on imu_cal_pkg, imu_cal_if, the block itself and imu_cal_result_checker.
`timescale 1ns / 1ps

module tb_imu_bias_calibration_activity_classifier;
    import imu_cal_pkg::*;

    localparam int SUM_WIDTH    = 32;
    localparam int DRAIN_CYCLES = 6 * (SUM_WIDTH + 2) + 2 + 40;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int PHASE_ITEMS  = 520;
    localparam int LONG_RUN     = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [THRESH_W-1:0] MAX_SQ = 32'd3221225472;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     mismatches;
    int                     outstanding;
    int                     send_idle_pct;
    int                     recv_idle_pct;
    int                     ready_hold_request;
    int                     samples_offered;
    int                     cycle_count;

    imu_cal_sample_if sample_ch ();
    imu_cal_result_if result_ch ();

    imu_bias_calibration_activity_classifier #(
        .SUM_WIDTH (SUM_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (sample_ch),
        .results   (result_ch)
    );

    imu_cal_result_checker #(
        .SUM_WIDTH (SUM_WIDTH)
    ) result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .samples     (sample_ch),
        .results     (result_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("** imu_bias_calibration_activity_classifier: FAILED **");
                $finish;
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        int hold_left;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (ready_hold_request != 0)
            begin
                hold_left = ready_hold_request;
                ready_hold_request = 0;
            end
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [NUM_AXES-1:0][AXIS_W-1:0] axes6(input int gx, input int gy,
                                                              input int gz, input int ax,
                                                              input int ay, input int az);
        return {az[15:0], ay[15:0], ax[15:0], gz[15:0], gy[15:0], gx[15:0]};
    endfunction

    // Full-range values, the extremes, and values scaled down to reach every magnitude.
    function automatic logic [NUM_AXES-1:0][AXIS_W-1:0] random_axes();
        logic [NUM_AXES-1:0][AXIS_W-1:0] v;
        logic [AXIS_W-1:0]               r;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            r = AXIS_W'($urandom);
            case ($urandom_range(7))
                0: r = 16'h8000;
                1: r = 16'h7fff;
                2, 3: r = $signed(r) >>> $urandom_range(15);
                default: ;
            endcase
            v[i] = r;
        end
        return v;
    endfunction

    // Base vector plus noise whose size is drawn per axis from shift_lo..15.
    function automatic logic [NUM_AXES-1:0][AXIS_W-1:0] jitter(
        input logic [NUM_AXES-1:0][AXIS_W-1:0] base, input int shift_lo);
        logic [NUM_AXES-1:0][AXIS_W-1:0] v;
        logic [AXIS_W-1:0]               r;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            r = AXIS_W'($urandom);
            v[i] = base[i] + AXIS_W'($signed(r) >>> $urandom_range(shift_lo, 15));
        end
        return v;
    endfunction

    function automatic logic [THRESH_W-1:0] random_square();
        logic [THRESH_W-1:0] v;
        case ($urandom_range(9))
            0: v = '0;
            1: v = MAX_SQ;
            default:
            begin
                v = $urandom >> $urandom_range(31);
                if (v > MAX_SQ)
                    v = MAX_SQ;
            end
        endcase
        return v;
    endfunction

    // Offers one sample and returns at the edge that accepts the transaction.
    task automatic offer_sample(input logic op, input logic [NUM_AXES-1:0][AXIS_W-1:0] axes);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.operation <= op;
        sample_ch.gyro_x    <= axes[0];
        sample_ch.gyro_y    <= axes[1];
        sample_ch.gyro_z    <= axes[2];
        sample_ch.accel_x   <= axes[3];
        sample_ch.accel_y   <= axes[4];
        sample_ch.accel_z   <= axes[5];
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        samples_offered++;
    endtask

    // Waits until every expected result has arrived and a calibration pass could finish.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic apply_config(input cfg_t c);
        write_reg(REG_CALIB_SAMPLES, {16'd0, c.calib_samples});
        write_reg(REG_GRAVITY_COUNTS, {17'd0, c.gravity_counts});
        write_reg(REG_ACCEL_STILL_SQ, c.accel_still_sq);
        write_reg(REG_ACCEL_WALK_SQ, c.accel_walk_sq);
        write_reg(REG_GYRO_STILL_SQ, c.gyro_still_sq);
        write_reg(REG_GYRO_WALK_SQ, c.gyro_walk_sq);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        cfg_t                            cfg;
        logic [NUM_AXES-1:0][AXIS_W-1:0] base;
        int                              run_len;
        int                              block_left;
        int                              phase_goal;
        bit                              first_block;

        ready_hold_request = 0;
        samples_offered    = 0;
        send_idle_pct      = 18;
        recv_idle_pct      = 81;
        cfg_we              <= 1'b0;
        cfg_index           <= '0;
        cfg_data            <= '0;
        sample_ch.valid     <= 1'b0;
        sample_ch.operation <= OP_MEASURE;
        sample_ch.gyro_x    <= '0;
        sample_ch.gyro_y    <= '0;
        sample_ch.gyro_z    <= '0;
        sample_ch.accel_x   <= '0;
        sample_ch.accel_y   <= '0;
        sample_ch.accel_z   <= '0;
        rst_n               <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cfg.calib_samples  = RST_CALIB_SAMPLES;
        cfg.gravity_counts = RST_GRAVITY_COUNTS;
        cfg.accel_still_sq = RST_ACCEL_STILL_SQ;
        cfg.accel_walk_sq  = RST_ACCEL_WALK_SQ;
        cfg.gyro_still_sq  = RST_GYRO_STILL_SQ;
        cfg.gyro_walk_sq   = RST_GYRO_WALK_SQ;

        // Before calibration the raw values pass straight through.
        offer_sample(OP_MEASURE, '0);
        offer_sample(OP_MEASURE, {6{16'h8000}});
        offer_sample(OP_MEASURE, {6{16'h7fff}});
        offer_sample(OP_MEASURE, {3{16'haaaa, 16'h5555}});
        offer_sample(OP_MEASURE, {3{16'h5555, 16'haaaa}});

        // Largest thresholds: the largest magnitude equals them and must not count as below.
        settle();
        cfg.accel_still_sq = MAX_SQ;
        cfg.accel_walk_sq  = MAX_SQ;
        cfg.gyro_still_sq  = MAX_SQ;
        cfg.gyro_walk_sq   = MAX_SQ;
        apply_config(cfg);
        offer_sample(OP_MEASURE, {6{16'h8000}});
        offer_sample(OP_MEASURE, {6{16'h8001}});

        // Zero thresholds: even a zero sample is running.
        settle();
        cfg.accel_still_sq = '0;
        cfg.accel_walk_sq  = '0;
        cfg.gyro_still_sq  = '0;
        cfg.gyro_walk_sq   = '0;
        apply_config(cfg);
        offer_sample(OP_MEASURE, '0);

        // Short run whose negative sums check truncation toward zero.
        settle();
        cfg.calib_samples  = 16'd3;
        cfg.accel_still_sq = RST_ACCEL_STILL_SQ;
        cfg.accel_walk_sq  = RST_ACCEL_WALK_SQ;
        cfg.gyro_still_sq  = RST_GYRO_STILL_SQ;
        cfg.gyro_walk_sq   = RST_GYRO_WALK_SQ;
        apply_config(cfg);
        offer_sample(OP_CALIBRATE, axes6(-7, 5, 100, -1, 2, 16000));
        offer_sample(OP_CALIBRATE, axes6(0, 0, 1, -1, 2, 16385));
        offer_sample(OP_CALIBRATE, axes6(0, 1, 0, 0, 1, 16390));
        offer_sample(OP_MEASURE, axes6(-5, 3, 30, 0, 0, 16384));

        // A zero count acts as one; extreme offsets and gravity make the Z offset wrap.
        settle();
        cfg.calib_samples  = '0;
        cfg.gravity_counts = 15'd32767;
        apply_config(cfg);
        offer_sample(OP_CALIBRATE, {6{16'h8000}});
        offer_sample(OP_MEASURE, {6{16'h7fff}});

        // Recalibration keeps the old offsets, then the count is lowered mid-run.
        settle();
        cfg.calib_samples  = 16'd4;
        cfg.gravity_counts = '0;
        apply_config(cfg);
        offer_sample(OP_CALIBRATE, axes6(100, -200, 300, -400, 500, -600));
        offer_sample(OP_CALIBRATE, axes6(101, -201, 301, -401, 501, -601));
        offer_sample(OP_MEASURE, axes6(1, 2, 3, 4, 5, 6));
        settle();
        cfg.calib_samples = 16'd2;
        apply_config(cfg);
        offer_sample(OP_CALIBRATE, axes6(102, -202, 302, -402, 502, -602));
        offer_sample(OP_MEASURE, axes6(1, 2, 3, 4, 5, 6));

        // A longer run with every axis pinned at an extreme.
        settle();
        send_idle_pct      = 0;
        cfg.calib_samples  = COUNT_W'(LONG_RUN);
        cfg.gravity_counts = RST_GRAVITY_COUNTS;
        apply_config(cfg);
        repeat (LONG_RUN)
            offer_sample(OP_CALIBRATE, {3{16'h8000, 16'h7fff}});
        offer_sample(OP_MEASURE, '0);

        // Random phases: new settings per block, mostly calibration runs and measurements.
        base = '0;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 18;
                    recv_idle_pct = 81;
                end
                1:
                begin
                    send_idle_pct = 81;
                    recv_idle_pct = 18;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_goal  = samples_offered + PHASE_ITEMS;
            first_block = 1'b1;
            while (samples_offered < phase_goal)
            begin
                settle();
                case ($urandom_range(9))
                    0: cfg.calib_samples = '0;
                    1: cfg.calib_samples = COUNT_W'($urandom_range(9, 40));
                    default: cfg.calib_samples = COUNT_W'($urandom_range(1, 8));
                endcase
                case ($urandom_range(5))
                    0: cfg.gravity_counts = '0;
                    1: cfg.gravity_counts = 15'd32767;
                    default: cfg.gravity_counts = GRAVITY_W'($urandom_range(32767));
                endcase
                cfg.accel_still_sq = random_square();
                cfg.accel_walk_sq  = random_square();
                cfg.gyro_still_sq  = random_square();
                cfg.gyro_walk_sq   = random_square();
                apply_config(cfg);

                // Hold the receiver off so the block fills up and stalls its input.
                if (first_block)
                begin
                    @(negedge clk);
                    ready_hold_request = HOLD_CYCLES;
                    @(posedge clk);
                    first_block = 1'b0;
                end

                block_left = $urandom_range(60, 160);
                while (block_left > 0)
                begin
                    if ($urandom_range(99) < 30)
                    begin
                        // A calibration run around a resting vector, sometimes cut short.
                        if ($urandom_range(1) == 0)
                            base = random_axes();
                        run_len = (cfg.calib_samples == '0) ? 1 : int'(cfg.calib_samples);
                        if ($urandom_range(9) == 0)
                            run_len = $urandom_range(1, run_len);
                        for (int k = 0; k < run_len && block_left > 0; k++)
                        begin
                            case ($urandom_range(19))
                                0: offer_sample(OP_MEASURE, random_axes());
                                1: offer_sample(OP_CALIBRATE, random_axes());
                                default: offer_sample(OP_CALIBRATE, jitter(base, 10));
                            endcase
                            block_left--;
                        end
                    end
                    else
                    begin
                        if ($urandom_range(1) == 0)
                            offer_sample(OP_MEASURE, jitter(base, 0));
                        else
                            offer_sample(OP_MEASURE, random_axes());
                        block_left--;
                    end
                end
            end
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("** imu_bias_calibration_activity_classifier: PASSED **");
        else
            $display("** imu_bias_calibration_activity_classifier: FAILED **");
        $finish;
    end

endmodule
